>>> hw/rtl/hmac_md5_keyed_digest_assert.svh
// assertion macros used by the top-level rtl file
`ifndef HMAC_MD5_KEYED_DIGEST_ASSERT_SVH
`define HMAC_MD5_KEYED_DIGEST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HMD5_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hmd5 check failed");

// next-cycle implication, disabled during reset
`define HMD5_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hmd5 check failed");

`endif

>>> hw/rtl/hmd5_pkg.sv
// types, constants and round tables for the keyed md5 digest block
`default_nettype none
package hmd5_pkg;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h0000_0080;
  // outer block length: (64 + 16) bytes in bits
  localparam logic [31:0] OUTER_LEN_BITS = 32'h0000_0280;
  localparam int unsigned NUM_KEY_WORDS = 8;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        digest_last;
  } out_t;

  // source of the message words for one compression
  typedef enum logic [2:0] {
    SRC_KEY_I,
    SRC_MSG,
    SRC_PAD1,
    SRC_PAD2,
    SRC_KEY_O,
    SRC_OUTER
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYI,
    ST_MSG,
    ST_PAD1,
    ST_PAD2,
    ST_KEYO,
    ST_OUTER,
    ST_OUT0,
    ST_OUT1
  } state_e;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_RUN,
    CP_FIN
  } core_ph_e;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;  6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;  6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;  6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;  6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;  6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;  6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;  6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;  6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;  6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;  6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;  6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;  6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;  6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;  6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;  6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;  6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;  6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;  6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;  6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;  6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by a round
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] g;
    case (rnd[5:4])
      2'd0: g = rnd[3:0];
      2'd1: g = 4'(rnd[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(rnd[3:0] * 4'd3 + 4'd5);
      default: g = 4'(rnd[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hmd5_buf.sv
// message block buffer: 16 words of 32 bits, byte-lane write, registered read
`default_nettype none
module hmd5_buf (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [5:0]  waddr_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic [3:0]  raddr_i,
  output logic      [31:0] rdata_o
);

  logic [31:0] mem [16];

  // byte write into its lane
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[5:2]][8*waddr_i[1:0] +: 8] <= wdata_i;
    end
  end

  // synchronous read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/hmd5_core.sv
// md5 round unit: one round per cycle, chaining value kept here
`default_nettype none
module hmd5_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hmd5_pkg::core_ctrl_t  ctrl_i,
  input  wire logic           [31:0] word_i,
  output logic                [3:0]  idx_o,
  output logic                       done_o,
  output logic                [31:0] chain_o [4]
);

  hmd5_pkg::core_ph_e ph_q, ph_d;
  logic [5:0]  rnd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] h_q [4];
  logic [31:0] f, x, rot;
  logic [63:0] dbl;

  // round function
  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    x   = a_q + f + hmd5_pkg::md5_k(rnd_q) + word_i;
    dbl = {x, x} << hmd5_pkg::md5_rot(rnd_q);
    rot = dbl[63:32];
  end

  // word index issued in the cycle before its round
  always_comb begin
    if (ph_q == hmd5_pkg::CP_RUN) begin
      idx_o = hmd5_pkg::md5_g(6'(rnd_q + 6'd1));
    end else begin
      idx_o = hmd5_pkg::md5_g(6'd0);
    end
  end

  // phase sequencing
  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      hmd5_pkg::CP_IDLE: if (ctrl_i.start) ph_d = hmd5_pkg::CP_RUN;
      hmd5_pkg::CP_RUN:  if (rnd_q == 6'd63) ph_d = hmd5_pkg::CP_FIN;
      hmd5_pkg::CP_FIN:  ph_d = hmd5_pkg::CP_IDLE;
      default:           ph_d = hmd5_pkg::CP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= hmd5_pkg::CP_IDLE;
      rnd_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == hmd5_pkg::CP_RUN) rnd_q <= rnd_q + 6'd1;
      else rnd_q <= '0;
    end
  end

  // working and chaining registers
  always_ff @(posedge clk_i) begin
    if (ph_q == hmd5_pkg::CP_IDLE && ctrl_i.start) begin
      if (ctrl_i.init) begin
        h_q[0] <= hmd5_pkg::IV_A; h_q[1] <= hmd5_pkg::IV_B;
        h_q[2] <= hmd5_pkg::IV_C; h_q[3] <= hmd5_pkg::IV_D;
        a_q <= hmd5_pkg::IV_A; b_q <= hmd5_pkg::IV_B;
        c_q <= hmd5_pkg::IV_C; d_q <= hmd5_pkg::IV_D;
      end else begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
      end
    end else if (ph_q == hmd5_pkg::CP_RUN) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end else if (ph_q == hmd5_pkg::CP_FIN) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
    end
  end

  assign done_o  = (ph_q == hmd5_pkg::CP_FIN);
  assign chain_o = h_q;

endmodule
`default_nettype wire

>>> hw/rtl/hmac_md5_keyed_digest.sv
// top level of the keyed md5 digest block
// Takes one message word (byte) per handshake; no new byte is taken while a
// compression runs. The first byte of a message also starts the inner key
// block, every 64th byte the compression of its block, and the last byte the
// padding block, outer key block and outer block, plus an extra padding block
// when the length needs one, before two digest words appear. Each compression
// is a start step, 64 rounds of one shared round unit at one round per cycle
// and a final add; message words come from a 16 x 32 buffer with a
// registered read.
`default_nettype none
`include "hmac_md5_keyed_digest_assert.svh"
module hmac_md5_keyed_digest #(
  parameter int unsigned LENGTH_COUNTER_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_idx_i,
  input  wire logic [63:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hmd5_pkg::in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hmd5_pkg::out_t        out_data_o
);

  hmd5_pkg::state_e state_q, state_d;
  logic [63:0] key_q [hmd5_pkg::NUM_KEY_WORDS];
  logic [LENGTH_COUNTER_BITS-1:0] cnt_q;
  logic        absorbed_q, last_q, full_q, run_q;
  logic [31:0] inner_q [4];
  logic [3:0]  widx_q;
  logic [3:0]  idx;
  logic [31:0] rdata, word, kword, chain [4];
  logic [7:0]  pad;
  logic [63:0] len_bits;
  logic        done, accept, in_comp;
  hmd5_pkg::src_e src;
  hmd5_pkg::core_ctrl_t ctrl;

  assign accept = in_valid_i && in_ready_o;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hmd5_pkg::NUM_KEY_WORDS; i++) key_q[i] <= '0;
    end else if (cfg_we_i && cfg_idx_i < 4'(hmd5_pkg::NUM_KEY_WORDS)) begin
      key_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  // block buffer
  hmd5_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cnt_q[5:0]),
    .wdata_i (in_data_i.msg_byte),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  // compression source per state
  always_comb begin
    case (state_q)
      hmd5_pkg::ST_KEYI:  src = hmd5_pkg::SRC_KEY_I;
      hmd5_pkg::ST_PAD1:  src = hmd5_pkg::SRC_PAD1;
      hmd5_pkg::ST_PAD2:  src = hmd5_pkg::SRC_PAD2;
      hmd5_pkg::ST_KEYO:  src = hmd5_pkg::SRC_KEY_O;
      hmd5_pkg::ST_OUTER: src = hmd5_pkg::SRC_OUTER;
      default:            src = hmd5_pkg::SRC_MSG;
    endcase
  end

  // message word assembly, aligned with the buffer read
  always_comb begin
    pad      = (src == hmd5_pkg::SRC_KEY_I) ? hmd5_pkg::IPAD_BYTE : hmd5_pkg::OPAD_BYTE;
    len_bits = (64'(cnt_q) + 64'(hmd5_pkg::BLOCK_BYTES)) << 3;
    kword    = key_q[widx_q[3:1]][32*widx_q[0] +: 32] ^ {4{pad}};
    word     = '0;
    case (src)
      hmd5_pkg::SRC_KEY_I, hmd5_pkg::SRC_KEY_O: word = kword;
      hmd5_pkg::SRC_MSG: word = rdata;
      hmd5_pkg::SRC_PAD1: begin
        for (int b = 0; b < 4; b++) begin
          if ({widx_q, 2'(b)} < cnt_q[5:0]) word[8*b +: 8] = rdata[8*b +: 8];
          else if ({widx_q, 2'(b)} == cnt_q[5:0]) word[8*b +: 8] = 8'h80;
        end
        if (cnt_q[5:0] < 6'd56) begin
          if (widx_q == 4'd14) word = len_bits[31:0];
          if (widx_q == 4'd15) word = len_bits[63:32];
        end
      end
      hmd5_pkg::SRC_PAD2: begin
        if (widx_q == 4'd14) word = len_bits[31:0];
        if (widx_q == 4'd15) word = len_bits[63:32];
      end
      hmd5_pkg::SRC_OUTER: begin
        if (widx_q < 4'd4) word = inner_q[widx_q[1:0]];
        else if (widx_q == 4'd4) word = hmd5_pkg::PAD_WORD;
        else if (widx_q == 4'd14) word = hmd5_pkg::OUTER_LEN_BITS;
      end
      default: word = rdata;
    endcase
  end

  always_ff @(posedge clk_i) begin
    widx_q <= idx;
  end

  assign in_comp = (state_q == hmd5_pkg::ST_KEYI) || (state_q == hmd5_pkg::ST_MSG) ||
                   (state_q == hmd5_pkg::ST_PAD1) || (state_q == hmd5_pkg::ST_PAD2) ||
                   (state_q == hmd5_pkg::ST_KEYO) || (state_q == hmd5_pkg::ST_OUTER);

  always_comb begin
    ctrl.start = in_comp && !run_q;
    ctrl.init  = (state_q == hmd5_pkg::ST_KEYI) || (state_q == hmd5_pkg::ST_KEYO);
  end

  // shared round unit
  hmd5_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .word_i  (word),
    .idx_o   (idx),
    .done_o  (done),
    .chain_o (chain)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmd5_pkg::ST_IDLE: begin
        if (accept) begin
          if (!absorbed_q) state_d = hmd5_pkg::ST_KEYI;
          else if (cnt_q[5:0] == 6'd63) state_d = hmd5_pkg::ST_MSG;
          else if (in_data_i.msg_last) state_d = hmd5_pkg::ST_PAD1;
        end
      end
      hmd5_pkg::ST_KEYI: begin
        if (done) begin
          if (full_q) state_d = hmd5_pkg::ST_MSG;
          else if (last_q) state_d = hmd5_pkg::ST_PAD1;
          else state_d = hmd5_pkg::ST_IDLE;
        end
      end
      hmd5_pkg::ST_MSG:
        if (done) state_d = last_q ? hmd5_pkg::ST_PAD1 : hmd5_pkg::ST_IDLE;
      hmd5_pkg::ST_PAD1:
        if (done) state_d = (cnt_q[5:0] >= 6'd56) ? hmd5_pkg::ST_PAD2 : hmd5_pkg::ST_KEYO;
      hmd5_pkg::ST_PAD2:  if (done) state_d = hmd5_pkg::ST_KEYO;
      hmd5_pkg::ST_KEYO:  if (done) state_d = hmd5_pkg::ST_OUTER;
      hmd5_pkg::ST_OUTER: if (done) state_d = hmd5_pkg::ST_OUT0;
      hmd5_pkg::ST_OUT0:  if (out_ready_i) state_d = hmd5_pkg::ST_OUT1;
      hmd5_pkg::ST_OUT1:  if (out_ready_i) state_d = hmd5_pkg::ST_IDLE;
      default:            state_d = hmd5_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == hmd5_pkg::ST_IDLE);
    out_valid_o = (state_q == hmd5_pkg::ST_OUT0) || (state_q == hmd5_pkg::ST_OUT1);
    out_data_o.digest_last = (state_q == hmd5_pkg::ST_OUT1);
    if (state_q == hmd5_pkg::ST_OUT1) out_data_o.digest_half = {chain[3], chain[2]};
    else out_data_o.digest_half = {chain[1], chain[0]};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hmd5_pkg::ST_IDLE;
      cnt_q      <= '0;
      absorbed_q <= 1'b0;
      last_q     <= 1'b0;
      full_q     <= 1'b0;
      run_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.start) run_q <= 1'b1;
      else if (done) run_q <= 1'b0;
      if (accept) begin
        cnt_q  <= cnt_q + LENGTH_COUNTER_BITS'(1);
        last_q <= in_data_i.msg_last;
        full_q <= (cnt_q[5:0] == 6'd63);
      end
      if (state_q == hmd5_pkg::ST_KEYI && done) absorbed_q <= 1'b1;
      if (state_q == hmd5_pkg::ST_OUT1 && out_ready_i) begin
        cnt_q      <= '0;
        absorbed_q <= 1'b0;
      end
    end
  end

  // inner digest capture as the outer key block starts
  always_ff @(posedge clk_i) begin
    if (state_q == hmd5_pkg::ST_KEYO && ctrl.start) inner_q <= chain;
  end

  `HMD5_ASSERT_NOW(a_ready_excl, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `HMD5_ASSERT_NOW(a_done_owned, clk_i, rst_ni, done, run_q && in_comp)
  `HMD5_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, accept && in_data_i.msg_last, !in_ready_o)

endmodule
`default_nettype wire

>>> verif/hmac_md5_keyed_digest_test.sv
// self-checking testbench for the keyed md5 digest block
`default_nettype none
module hmac_md5_keyed_digest_test;

  localparam int unsigned DIGEST_GAP = 400;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [3:0] KEY_IDX_LAST = 4'(hmd5_pkg::NUM_KEY_WORDS - 1);
  localparam logic [3:0] IDX_UNUSED = 4'd9;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [3:0] cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  hmd5_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  hmd5_pkg::out_t out_data_o;

  hmac_md5_keyed_digest dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // predictor state
  logic [63:0] key_regs [hmd5_pkg::NUM_KEY_WORDS];
  logic [31:0] chain [4];
  logic [7:0] msg_block [hmd5_pkg::BLOCK_BYTES];
  logic [63:0] msg_count;
  logic key_in_chain;

  hmd5_pkg::in_t byte_queue [$];
  hmd5_pkg::out_t digest_queue [$];
  int unsigned error_count;
  int unsigned stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [31:0] round_const(input int i);
    real v;
    v = $sin(i + 1);
    if (v < 0) v = -v;
    return 32'(longint'($floor(v * 4294967296.0)));
  endfunction

  // one md5 compression of a 64-byte block into the chain
  function automatic void md5_compress(input logic [7:0] blk [hmd5_pkg::BLOCK_BYTES]);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, x, t;
    int unsigned g, s;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5*i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3*i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7*i) % 16;
      end
      case ((i / 16) * 4 + i % 4)
        0: s = 7;  1: s = 12; 2: s = 17; 3: s = 22;
        4: s = 5;  5: s = 9;  6: s = 14; 7: s = 20;
        8: s = 4;  9: s = 11; 10: s = 16; 11: s = 23;
        12: s = 6; 13: s = 10; 14: s = 15; default: s = 21;
      endcase
      x = a + f + round_const(i) + m[g];
      t = d; d = c; c = b;
      b = b + ((x << s) | (x >> (32 - s)));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function automatic void chain_reset();
    chain[0] = hmd5_pkg::IV_A; chain[1] = hmd5_pkg::IV_B;
    chain[2] = hmd5_pkg::IV_C; chain[3] = hmd5_pkg::IV_D;
  endfunction

  function automatic void absorb_key_block(input logic [7:0] pad);
    logic [7:0] blk [hmd5_pkg::BLOCK_BYTES];
    for (int i = 0; i < hmd5_pkg::BLOCK_BYTES; i++)
      blk[i] = key_regs[i / 8][8*(i % 8) +: 8] ^ pad;
    chain_reset();
    md5_compress(blk);
  endfunction

  // advance the predictor by one accepted byte
  function automatic void predict_digest(input hmd5_pkg::in_t w);
    logic [7:0] blk [hmd5_pkg::BLOCK_BYTES];
    logic [31:0] inner [4];
    logic [63:0] bits;
    int unsigned pos;
    if (!key_in_chain) begin
      absorb_key_block(hmd5_pkg::IPAD_BYTE);
      key_in_chain = 1'b1;
    end
    pos = msg_count[5:0];
    msg_block[pos] = w.msg_byte;
    msg_count++;
    if (pos == 63) md5_compress(msg_block);
    if (!w.msg_last) return;
    // inner padding and length
    pos = (pos + 1) % 64;
    blk = msg_block;
    blk[pos] = 8'h80;
    for (int i = pos + 1; i < hmd5_pkg::BLOCK_BYTES; i++) blk[i] = 8'h00;
    if (pos >= 56) begin
      md5_compress(blk);
      for (int i = 0; i < hmd5_pkg::BLOCK_BYTES; i++) blk[i] = 8'h00;
    end
    bits = (msg_count + 64'd64) << 3;
    for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
    md5_compress(blk);
    inner = chain;
    // outer hash
    absorb_key_block(hmd5_pkg::OPAD_BYTE);
    for (int i = 0; i < hmd5_pkg::BLOCK_BYTES; i++) blk[i] = 8'h00;
    for (int i = 0; i < 16; i++) blk[i] = inner[i / 4][8*(i % 4) +: 8];
    blk[16] = 8'h80;
    blk[56] = hmd5_pkg::OUTER_LEN_BITS[7:0];
    blk[57] = hmd5_pkg::OUTER_LEN_BITS[15:8];
    md5_compress(blk);
    digest_queue.push_back('{digest_half: {chain[1], chain[0]}, digest_last: 1'b0});
    digest_queue.push_back('{digest_half: {chain[3], chain[2]}, digest_last: 1'b1});
    msg_count = '0;
    key_in_chain = 1'b0;
    chain_reset();
  endfunction

  // byte driver with random gaps and a pause hook
  int unsigned send_gap;
  logic hold_off;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap <= 0;
    end else if (in_valid_i && in_ready_o) begin
      predict_digest(in_data_i);
      void'(byte_queue.pop_front());
      send_gap <= $urandom_range(3, 0) == 0 ? $urandom_range(19, 0) : 0;
      in_valid_i <= 1'b0;
    end else if (!in_valid_i && byte_queue.size() > 0 && !hold_off) begin
      if (send_gap == 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= byte_queue[0];
      end else begin
        send_gap <= send_gap - 1;
      end
    end
  end

  // digest monitor with random back pressure
  int unsigned recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("digest word with nothing expected");
        end else begin
          if (out_data_o.digest_half !== digest_queue[0].digest_half)
            report_mismatch($sformatf("digest_half got %h exp %h",
              out_data_o.digest_half, digest_queue[0].digest_half));
          if (out_data_o.digest_last !== digest_queue[0].digest_last)
            report_mismatch($sformatf("digest_last got %b exp %b",
              out_data_o.digest_last, digest_queue[0].digest_last));
          void'(digest_queue.pop_front());
        end
        recv_gap <= $urandom_range(2, 0) == 0 ? $urandom_range(19, 0) : 0;
        out_ready_i <= 1'b0;
      end else if (recv_gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        recv_gap <= recv_gap - 1;
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (byte_queue.size() == 0 && digest_queue.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_key(input logic [3:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= KEY_IDX_LAST) key_regs[idx] = val;
  endtask

  task automatic load_key(input int kind);
    logic [63:0] v;
    for (int i = 0; i < hmd5_pkg::NUM_KEY_WORDS; i++) begin
      case (kind)
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      if (kind == 3 && i >= 2) v = '0;
      write_key(4'(i), v);
    end
  endtask

  // wait for all queued bytes and digests, then let the block settle
  task automatic drain();
    while (byte_queue.size() > 0 || digest_queue.size() > 0 || in_valid_i) begin
      @(posedge clk_i);
      if (stall_cycles > STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    repeat (DIGEST_GAP) @(posedge clk_i);
  endtask

  task automatic queue_message(input int unsigned len, input int mode);
    hmd5_pkg::in_t w;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: w.msg_byte = 8'h00;
        1: w.msg_byte = 8'hff;
        default: w.msg_byte = 8'($urandom);
      endcase
      w.msg_last = (i == len - 1);
      byte_queue.push_back(w);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    hold_off = 1'b0;
    error_count = 0;
    for (int i = 0; i < hmd5_pkg::NUM_KEY_WORDS; i++) key_regs[i] = '0;
    chain_reset();
    msg_count = '0;
    key_in_chain = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key, short messages, pad edges 55, 56, 64, 65
    queue_message(1, 0);
    queue_message(1, 1);
    queue_message(2, 2);
    queue_message(3, 2);
    drain();
    load_key(1);
    write_key(IDX_UNUSED, '1);
    queue_message(55, 2);
    queue_message(56, 1);
    queue_message(64, 2);
    queue_message(65, 0);
    drain();

    // random messages under varied keys, mostly short
    sent = 0;
    for (int phase = 0; sent < 1550; phase++) begin
      load_key(phase % 4);
      for (int m = 0; m < 8; m++) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(140, 50) : $urandom_range(20, 1);
        queue_message(len, 2);
        sent += len;
      end
      // hold the sender until every pending digest is back
      if (phase == 1) begin
        while (digest_queue.size() == 0) @(posedge clk_i);
        hold_off = 1'b1;
        while (digest_queue.size() > 0) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/hmd5_pkg.sv
hw/rtl/hmd5_buf.sv
hw/rtl/hmd5_core.sv
hw/rtl/hmac_md5_keyed_digest.sv
verif/hmac_md5_keyed_digest_test.sv
